// ----- hdl/crle_pkg.sv -----
// Shared types and codes for the column chunk run-length decoder.
`default_nettype none
package crle_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // Operation codes on the input channel
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   // Configuration register indexes
   localparam logic [1:0] CSR_ELEMENT_BYTES = 2'd0;
   localparam logic [1:0] CSR_RLE_MODE      = 2'd1;
   localparam logic [1:0] CSR_ROW_LIMIT     = 2'd2;

   // Decode phases
   localparam logic [2:0] PH_HEADER    = 3'd0;
   localparam logic [2:0] PH_VALUE     = 3'd1;
   localparam logic [2:0] PH_COUNT     = 3'd2;
   localparam logic [2:0] PH_EXPAND    = 3'd3;
   localparam logic [2:0] PH_EXHAUSTED = 3'd4;
   localparam logic [2:0] PH_HOLD      = 3'd6;

   // Result status codes
   localparam logic [2:0] ST_ELEMENT = 3'd0;
   localparam logic [2:0] ST_TAKEN   = 3'd1;
   localparam logic [2:0] ST_BUSY    = 3'd2;
   localparam logic [2:0] ST_NONE    = 3'd3;
   localparam logic [2:0] ST_OVERRUN = 3'd4;

   localparam logic [3:0] ELEMENT_BYTES_RESET = 4'd4;

   // Classified item passed from front to back
   typedef struct packed {
      logic       is_pull;
      logic [7:0] data;
   } item_type;

endpackage
`default_nettype wire

// ----- hdl/crle_front.sv -----
// Front end: takes items, classifies them and queues them for the decoder.
`default_nettype none
module crle_front #(
   parameter int QUEUE_DEPTH = crle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire logic [7:0]         req_data_byte,
   output logic                    head_valid,
   output crle_pkg::item_type      head_item,
   input  wire logic               head_pop
);
   import crle_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   item_type         queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   item_type         new_item;
   logic             push;
   logic             pop;

   assign req_stall  = (count_ff == CNT_FULL);
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign head_item  = queue_ff[rd_ptr_ff];
   assign pop        = head_pop && head_valid;

   always_comb begin
      new_item.is_pull = (req_operation == OP_PULL);
      new_item.data    = req_data_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_item;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CNT_FULL) |-> req_stall)
      else $error("full queue not stalling input");

   a_head_held: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !head_pop) |=> head_valid)
      else $error("queued item lost without pop");

endmodule
`default_nettype wire

// ----- hdl/crle_back.sv -----
// Back end: decode state, configuration registers and the result register.
`default_nettype none
module crle_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [1:0]         csr_index,
   input  wire logic [31:0]        csr_write_data,
   input  wire logic               head_valid,
   input  wire crle_pkg::item_type head_item,
   output logic                    head_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [63:0]             rsp_element_value,
   output logic                    rsp_is_last,
   output logic [2:0]              rsp_status
);
   import crle_pkg::*;

   logic [3:0]  element_bytes_ff;
   logic        rle_mode_ff;
   logic [31:0] row_limit_ff;

   logic [2:0]  phase_ff, phase_in;
   logic [2:0]  byte_index_ff, byte_index_in;
   logic [63:0] assembly_ff, assembly_in;
   logic [63:0] run_value_ff, run_value_in;
   logic [31:0] run_remaining_ff, run_remaining_in;
   logic [31:0] runs_left_ff, runs_left_in;
   logic [31:0] rows_emitted_ff, rows_emitted_in;

   logic        rsp_valid_ff;
   logic [63:0] value_ff, value_in;
   logic        last_ff, last_in;
   logic [2:0]  status_ff, status_in;

   logic [3:0]  width_bytes;
   logic [3:0]  need;
   logic [63:0] merged;
   logic        collect_done;
   logic [31:0] runs_left_dec;
   logic [31:0] run_remaining_dec;
   logic [2:0]  after_run_phase;
   logic        restart;

   assign head_pop  = head_valid && (!rsp_valid_ff || !rsp_stall);
   assign restart   = csr_write_enable &&
                      (csr_index == CSR_ELEMENT_BYTES || csr_index == CSR_RLE_MODE ||
                       csr_index == CSR_ROW_LIMIT);

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_value = value_ff;
   assign rsp_is_last       = last_ff;
   assign rsp_status        = status_ff;

   always_comb begin
      if (element_bytes_ff == 4'd0) begin
         width_bytes = 4'd1;
      end else if (element_bytes_ff > 4'd8) begin
         width_bytes = 4'd8;
      end else begin
         width_bytes = element_bytes_ff;
      end
      // header and repeat counts are always 32-bit
      if (rle_mode_ff && (phase_ff == PH_HEADER || phase_ff == PH_COUNT)) begin
         need = 4'd4;
      end else begin
         need = width_bytes;
      end
      merged       = assembly_ff | (64'(head_item.data) << {byte_index_ff, 3'b000});
      collect_done = ({1'b0, byte_index_ff} + 4'd1) >= need;
   end

   assign runs_left_dec     = runs_left_ff - 32'd1;
   assign run_remaining_dec = run_remaining_ff - 32'd1;

   always_comb begin
      phase_in         = phase_ff;
      byte_index_in    = byte_index_ff;
      assembly_in      = assembly_ff;
      run_value_in     = run_value_ff;
      run_remaining_in = run_remaining_ff;
      runs_left_in     = runs_left_ff;
      rows_emitted_in  = rows_emitted_ff;
      value_in         = '0;
      last_in          = 1'b0;
      status_in        = ST_NONE;
      after_run_phase  = (runs_left_ff == 32'd0) ? PH_EXHAUSTED : PH_VALUE;

      if (!head_item.is_pull) begin
         if ((!rle_mode_ff && phase_ff == PH_HOLD) ||
             (rle_mode_ff && phase_ff != PH_HEADER && phase_ff != PH_VALUE &&
              phase_ff != PH_COUNT)) begin
            status_in = ST_BUSY;
         end else begin
            status_in = ST_TAKEN;
            if (collect_done) begin
               byte_index_in = '0;
               assembly_in   = '0;
               if (!rle_mode_ff) begin
                  run_value_in = merged;
                  phase_in     = PH_HOLD;
               end else begin
                  case (phase_ff)
                     PH_HEADER: begin
                        runs_left_in = merged[31:0];
                        phase_in     = (merged[31:0] == 32'd0) ? PH_EXHAUSTED : PH_VALUE;
                     end
                     PH_VALUE: begin
                        run_value_in = merged;
                        phase_in     = PH_COUNT;
                     end
                     PH_COUNT: begin
                        run_remaining_in = merged[31:0];
                        runs_left_in     = runs_left_dec;
                        if (merged[31:0] != 32'd0) begin
                           phase_in = PH_EXPAND;
                        end else begin
                           phase_in = (runs_left_dec == 32'd0) ? PH_EXHAUSTED : PH_VALUE;
                        end
                     end
                     default: begin
                        phase_in = phase_ff;
                     end
                  endcase
               end
            end else begin
               byte_index_in = byte_index_ff + 3'd1;
               assembly_in   = merged;
            end
         end
      end else if (rows_emitted_ff >= row_limit_ff) begin
         status_in = ST_OVERRUN;
      end else begin
         if (!rle_mode_ff) begin
            if (phase_ff == PH_HOLD) begin
               value_in  = run_value_ff;
               phase_in  = PH_HEADER;
               status_in = ST_ELEMENT;
            end
         end else if (phase_ff == PH_EXPAND) begin
            value_in         = run_value_ff;
            run_remaining_in = run_remaining_dec;
            if (run_remaining_dec == 32'd0) begin
               phase_in = after_run_phase;
            end
            status_in = ST_ELEMENT;
         end else if (phase_ff != PH_HEADER && phase_ff != PH_VALUE &&
                      phase_ff != PH_COUNT) begin
            // runs used up: rows still owed read as zero
            status_in = ST_ELEMENT;
         end
         if (status_in == ST_ELEMENT) begin
            last_in         = ({1'b0, rows_emitted_ff} + 33'd1) == {1'b0, row_limit_ff};
            rows_emitted_in = rows_emitted_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         element_bytes_ff <= ELEMENT_BYTES_RESET;
         rle_mode_ff      <= 1'b0;
         row_limit_ff     <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_ELEMENT_BYTES: element_bytes_ff <= csr_write_data[3:0];
            CSR_RLE_MODE:      rle_mode_ff      <= csr_write_data[0];
            CSR_ROW_LIMIT:     row_limit_ff     <= csr_write_data;
            default:           element_bytes_ff <= element_bytes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         phase_ff         <= PH_HEADER;
         byte_index_ff    <= '0;
         assembly_ff      <= '0;
         run_value_ff     <= '0;
         run_remaining_ff <= '0;
         runs_left_ff     <= '0;
         rows_emitted_ff  <= '0;
      end else if (head_pop) begin
         phase_ff         <= phase_in;
         byte_index_ff    <= byte_index_in;
         assembly_ff      <= assembly_in;
         run_value_ff     <= run_value_in;
         run_remaining_ff <= run_remaining_in;
         runs_left_ff     <= runs_left_in;
         rows_emitted_ff  <= rows_emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (head_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (head_pop) begin
         value_ff  <= value_in;
         last_ff   <= last_in;
         status_ff <= status_in;
      end
   end

   a_non_element_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_ELEMENT) |-> (value_ff == '0 && !last_ff))
      else $error("non-element result carries data");

   a_rows_bounded: assert property (@(posedge clock) disable iff (reset)
      rows_emitted_ff <= row_limit_ff)
      else $error("rows emitted beyond row count");

   a_plain_phases: assert property (@(posedge clock) disable iff (reset)
      !rle_mode_ff |-> (phase_ff == PH_HEADER || phase_ff == PH_HOLD))
      else $error("run-length phase reached in plain mode");

endmodule
`default_nettype wire

// ----- hdl/column_chunk_rle_decoder.sv -----
// An accepted item is written into the queue, then popped by the back end into the result register on rsp_*.
// Throughput: one item per cycle while rsp_stall is low; the decode state is updated by a single pop of the queue.
// A queue between front and back (QUEUE_DEPTH items) lets input and result stall apart.
// Synchronous active-high reset empties the queue and result register, puts the config
// registers at reset values and returns the decoder to the run count header.
`default_nettype none
module column_chunk_rle_decoder #(
   parameter int QUEUE_DEPTH = crle_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_operation,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_element_value,
   output logic             rsp_is_last,
   output logic [2:0]       rsp_status
);
   import crle_pkg::*;

   logic     head_valid;
   item_type head_item;
   logic     head_pop;

   crle_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_pop      (head_pop)
   );

   crle_back u_back (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .head_valid        (head_valid),
      .head_item         (head_item),
      .head_pop          (head_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_element_value (rsp_element_value),
      .rsp_is_last       (rsp_is_last),
      .rsp_status        (rsp_status)
   );

endmodule
`default_nettype wire
